// ===== src/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int IDX_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RECLAIM = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

// ===== src/bsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsa_summary.sv =====
// Per-word nonempty summary flags and lowest nonempty word search.
`timescale 1ns / 1ps

module bsa_summary #(
  parameter int WORDS = 32,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          upd_en,
  input  logic [AW-1:0] upd_addr,
  input  logic          upd_nonempty,
  output logic          any_free,
  output logic [AW-1:0] first_word
);

  logic [WORDS-1:0] nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '1;
    end else if (upd_en) begin
      nonempty[upd_addr] <= upd_nonempty;
    end
  end

  always_comb begin
    any_free   = 1'b0;
    first_word = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        any_free   = 1'b1;
        first_word = AW'(i);
      end
    end
  end

endmodule

// ===== src/bitmap_slot_allocator.sv =====
// An item is accepted in ST_IDLE and its bitmap word is read; in ST_LOOKUP the result is registered
// once the output register is free, and no new item is taken until this read-modify-write ends.
// Allocate finds the lowest nonempty word from a flag register, reads it, encodes and writes back.
// Reset: a clearing pass writes all ones into every bitmap word, during which no item is
// accepted; slots_in_use resets to 1024.
// WORD_BITS must be a power of two.
`timescale 1ns / 1ps

module bitmap_slot_allocator #(
  parameter int CAPACITY  = bsa_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bsa_pkg::SIZE_W-1:0]  cfg_wdata,   // slots_in_use
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,     // [9:0] slot_index
  input  logic                        s_tuser,     // op
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,     // [9:0] granted_slot
  output logic [bsa_pkg::STATUS_W-1:0] m_tuser     // [1:0] status
);

  import bsa_pkg::*;

  localparam int WORDS  = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int GW     = AW + BW;
  localparam int CAP_W  = $clog2(CAPACITY + 1);
  localparam int SZW    = (CAP_W > SIZE_W) ? CAP_W : SIZE_W;
  localparam int CW0    = (GW > SZW) ? GW : SZW;
  localparam int CW     = (CW0 > IDX_W) ? CW0 : IDX_W;
  localparam int IXW    = IDX_W + AW;

  state_t state, state_next;

  logic [SIZE_W-1:0]    slots_in_use;
  logic [AW-1:0]        clr_addr;
  logic                 op_q;
  logic [IDX_W-1:0]     idx_q;
  logic [AW-1:0]        word_q;
  logic                 hit_q;

  logic                 accept;
  logic                 finish;
  logic [CW-1:0]        size_eff;
  logic [IXW-1:0]       idx_shift;
  logic [AW-1:0]        idx_word;
  logic                 any_free;
  logic [AW-1:0]        first_word;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] rd_data;

  logic                 bit_found;
  logic [BW-1:0]        bit_pos;
  logic [BW-1:0]        bit_sel;
  logic [WORD_BITS-1:0] bit_mask;
  logic [CW-1:0]        global_idx;
  logic                 alloc_ok;
  logic                 reclaim_oob;
  logic                 upd_en;
  logic [WORD_BITS-1:0] word_new;
  logic [STATUS_W-1:0]  status_res;
  logic [IDX_W-1:0]     granted_res;

  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_LOOKUP) && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE);

  assign size_eff = (CW'(slots_in_use) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(slots_in_use);

  assign idx_shift = IXW'(s_tdata[IDX_W-1:0]) >> BW;
  assign idx_word  = idx_shift[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_tuser;
      idx_q  <= s_tdata[IDX_W-1:0];
      word_q <= (s_tuser == OP_ALLOC) ? first_word : idx_word;
      hit_q  <= any_free;
    end
    if (finish) begin
      m_tdata <= {{(16 - IDX_W){1'b0}}, granted_res};
      m_tuser <= status_res;
    end
  end

  always_comb begin
    bit_found = 1'b0;
    bit_pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rd_data[i]) begin
        bit_found = 1'b1;
        bit_pos   = BW'(i);
      end
    end
  end

  assign global_idx  = CW'({word_q, bit_pos});
  assign alloc_ok    = hit_q && bit_found && (global_idx < size_eff);
  assign reclaim_oob = CW'(idx_q) >= size_eff;
  assign bit_sel     = (op_q == OP_ALLOC) ? bit_pos : idx_q[BW-1:0];
  assign bit_mask    = WORD_BITS'(1) << bit_sel;
  assign word_new    = (op_q == OP_ALLOC) ? (rd_data & ~bit_mask) : (rd_data | bit_mask);
  assign upd_en      = finish && ((op_q == OP_ALLOC) ? alloc_ok : !reclaim_oob);

  always_comb begin
    status_res  = STATUS_OK;
    granted_res = '0;
    if (op_q == OP_ALLOC) begin
      if (alloc_ok) begin
        granted_res = global_idx[IDX_W-1:0];
      end else begin
        status_res = STATUS_FULL;
      end
    end else if (reclaim_oob) begin
      status_res = STATUS_OOB;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '1;
    end else begin
      ram_we    = upd_en;
      ram_waddr = word_q;
      ram_wdata = word_new;
    end
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr ((s_tuser == OP_ALLOC) ? first_word : idx_word),
    .rdata (rd_data)
  );

  bsa_summary #(
    .WORDS (WORDS)
  ) u_summary (
    .clk          (clk),
    .rst          (rst),
    .upd_en       (upd_en),
    .upd_addr     (word_q),
    .upd_nonempty (|word_new),
    .any_free     (any_free),
    .first_word   (first_word)
  );

endmodule

// ===== test/bitmap_slot_allocator_test.sv =====
// Stream testbench for the bitmap slot allocator with a built-in free-map predictor.
`timescale 1ns / 1ps

module bitmap_slot_allocator_test;
  import bsa_pkg::*;

  localparam int MAP_WORDS      = CAPACITY_DEF / WORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] slot_index;
  } slot_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted;
  } slot_grant_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_SPARSE,
    RX_BLOCKED
  } rx_mode_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [SIZE_W-1:0]   cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  logic [WORD_BITS_DEF-1:0] vacancy [MAP_WORDS];
  logic [SIZE_W-1:0]        pool_size;

  slot_req_t   request_q [$];
  slot_grant_t grant_q [$];

  int       errors;
  int       idle_cycles;
  int       held_est;
  logic     item_taken;
  int       burst_left;
  int       gap_left;
  logic     drain_wait;
  rx_mode_t rx_mode;
  int       rx_mode_cycles;
  int       stall_left;
  logic     busy;
  slot_grant_t want;

  bitmap_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic slot_grant_t serve_request(input slot_req_t req);
    slot_grant_t res;
    int lim;
    int s;
    int idx;
    lim = (pool_size > CAPACITY_DEF) ? CAPACITY_DEF : int'(pool_size);
    idx = int'(req.slot_index);
    res.status  = STATUS_FULL;
    res.granted = '0;
    if (req.op == OP_ALLOC) begin
      for (s = 0; s < lim; s++) begin
        if (vacancy[s / WORD_BITS_DEF][s % WORD_BITS_DEF]) begin
          vacancy[s / WORD_BITS_DEF][s % WORD_BITS_DEF] = 1'b0;
          res.granted = s[IDX_W-1:0];
          res.status  = STATUS_OK;
          break;
        end
      end
    end else if (idx >= lim) begin
      res.status = STATUS_OOB;
    end else begin
      vacancy[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF] = 1'b1;
      res.status = STATUS_OK;
    end
    return res;
  endfunction

  // predict on accepted items, check accepted results
  always @(posedge clk) begin
    busy = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      busy = 1'b1;
      item_taken = 1'b1;
      grant_q.push_back(serve_request(request_q.pop_front()));
    end
    if (!rst && m_tvalid && m_tready) begin
      busy = 1'b1;
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: status %0d slot %0d", m_tuser, m_tdata);
      end else begin
        want = grant_q.pop_front();
        if (m_tuser !== want.status || m_tdata !== {6'b0, want.granted}) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("mismatch: expected status %0d slot %0d, got status %0d tdata %0d",
                     want.status, want.granted, m_tuser, m_tdata);
        end
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // sender: bursts with gaps, occasionally hold until all results are back
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
    end else if (gap_left != 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (request_q.size() == 0 || (drain_wait && grant_q.size() != 0)) begin
      s_tvalid <= 1'b0;
    end else begin
      drain_wait = 1'b0;
      s_tvalid <= 1'b1;
      s_tdata  <= {6'b0, request_q[0].slot_index};
      s_tuser  <= request_q[0].op;
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        drain_wait = ($urandom_range(0, 15) == 0);
      end else begin
        burst_left--;
      end
    end
    item_taken = 1'b0;
  end

  // receiver: stall pattern changes to a randomly chosen mode at regular intervals
  always @(negedge clk) begin
    rx_mode_cycles++;
    if (rx_mode_cycles == 48) begin
      rx_mode_cycles = 0;
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      case (rx_mode)
        RX_CHOPPY:  stall_left = $urandom_range(0, 1);
        RX_SPARSE:  stall_left = 3;
        RX_BLOCKED: stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : 0;
        default:    stall_left = 0;
      endcase
    end
  end

  task automatic add_item(input logic op, input int idx);
    slot_req_t req;
    req.op         = op;
    req.slot_index = idx[IDX_W-1:0];
    request_q.push_back(req);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || grant_q.size() != 0 || s_tvalid) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pool_size = value;
  endtask

  // allocations and reclaims; reclaims mostly aim near the allocated low slots
  task automatic random_run(input logic [SIZE_W-1:0] size, input int count, input int alloc_pct);
    int i;
    int lim;
    int hi;
    write_size(size);
    lim = (size > CAPACITY_DEF) ? CAPACITY_DEF : int'(size);
    if (held_est > lim)
      held_est = lim;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        add_item(OP_ALLOC, $urandom_range(0, 1023));
        if (held_est < lim)
          held_est++;
      end else if ($urandom_range(0, 9) == 0) begin
        add_item(OP_RECLAIM, $urandom_range(0, 1023));
      end else begin
        hi = held_est + 2;
        if (hi > 1023)
          hi = 1023;
        add_item(OP_RECLAIM, $urandom_range(0, hi));
        if (held_est > 0)
          held_est--;
      end
    end
  endtask

  initial begin
    int w;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    m_tready       = 1'b0;
    errors         = 0;
    idle_cycles    = 0;
    item_taken     = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    drain_wait     = 1'b0;
    rx_mode        = RX_STEADY;
    rx_mode_cycles = 0;
    stall_left     = 0;
    pool_size      = SIZE_RESET;
    for (w = 0; w < MAP_WORDS; w++)
      vacancy[w] = '1;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    add_item(OP_ALLOC, 0);
    add_item(OP_ALLOC, 1023);
    add_item(OP_ALLOC, 0);
    add_item(OP_RECLAIM, 1);
    add_item(OP_ALLOC, 0);
    add_item(OP_RECLAIM, 1023);
    add_item(OP_RECLAIM, 0);
    add_item(OP_RECLAIM, 0);
    write_size(0);
    add_item(OP_ALLOC, 0);
    add_item(OP_RECLAIM, 0);
    add_item(OP_RECLAIM, 1023);
    write_size(1);
    add_item(OP_ALLOC, 0);
    add_item(OP_ALLOC, 0);
    add_item(OP_RECLAIM, 1);
    add_item(OP_RECLAIM, 0);
    write_size(2047);
    add_item(OP_RECLAIM, 1023);
    add_item(OP_ALLOC, 512);
    add_item(OP_ALLOC, 0);
    held_est = 3;

    random_run(1024, 150, 70);
    random_run(40, 120, 75);
    random_run(0, 30, 50);
    random_run(2047, 100, 50);
    random_run(1, 40, 50);
    random_run(33, 100, 65);
    repeat (3)
      random_run($urandom_range(1, 2047), 80, 60);
    random_run(32, 80, 70);
    random_run(1024, 80, 55);

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && grant_q.size() == 0)
      $display("bitmap_slot_allocator_test: PASS");
    else
      $display("bitmap_slot_allocator_test: FAIL");
    $finish;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("bitmap_slot_allocator_test: FAIL");
    $finish;
  end

endmodule
